>>> rtl/core/encoder_s_method_velocity_defines.svh
// ----------------------------------------------------------------------------
// Encoder S-method velocity: assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ENCODER_S_METHOD_VELOCITY_DEFINES_SVH
`define ENCODER_S_METHOD_VELOCITY_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define ESMV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define ESMV_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/esmv_pkg.sv
// ----------------------------------------------------------------------------
// Encoder S-method velocity: package
// Widths, fixed-point constants, reset values and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package esmv_pkg;

    // Port widths
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int COUNT_W    = 32;
    localparam int VEL_W      = 32;

    // Internal widths
    localparam int WIN_W      = 14;
    localparam int DECAY_W    = 17;

    // Restart the window once it runs past this many held samples
    localparam int HOLD_LIMIT = 10000;

    // Q0.16 one and rounding half
    localparam logic [DECAY_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [32:0]        HALF_Q16 = 33'd32768;

    // Reset values of the configuration registers
    localparam logic [31:0]        SCALE_RST       = 32'd411775;
    localparam logic [DECAY_W-1:0] DECAY_RST       = 17'd59299;
    // Rounded square of DECAY_RST in Q0.16
    localparam logic [DECAY_W-1:0] DECAY_POWER_RST = 17'd53656;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VELOCITY_SCALE = 1'b0,
        REG_DECAY_PER_SAMPLE = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/core/encoder_s_method_velocity.sv
// A changed difference runs product, sum, scale, divide and filter (a first sample adds a
// power step; saturation skips the divide); a held sample updates the decay power and a
// restart pushes directly. One sample at a time, taken only in idle after the result is
// loaded. The 32-step restoring divide by 2k dominates the changed-difference path.
// Reset: configuration takes its reset values, history and filter state clear to zero,
// window length is two, and the sequencer returns to idle with no result pending.
// ----------------------------------------------------------------------------
// Encoder S-method velocity estimator
// Forms pulse differences, trapezoidal window sums, scale/k conversion and a
// first-order low-pass filter, all on one shared multiplier and a bit-serial
// divider under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "encoder_s_method_velocity_defines.svh"

module encoder_s_method_velocity (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_write,
    input  wire logic [esmv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [esmv_pkg::CFG_DATA_W-1:0]   cfg_data,
    // sample channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [esmv_pkg::COUNT_W-1:0] pulse_count,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [esmv_pkg::VEL_W-1:0]      velocity,
    output logic                                   updated
);

    import esmv_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_INITP,
        ST_DECIDE,
        ST_PWR,
        ST_PROD,
        ST_S2,
        ST_MAG,
        ST_MLO,
        ST_MHI,
        ST_NSUM,
        ST_OVF,
        ST_DIV,
        ST_RAW,
        ST_FDIFF,
        ST_FMUL,
        ST_FOUT,
        ST_PUSH
    } state_t;

    // Control and architectural state
    state_t             state_reg, state_next;
    logic [31:0]        scale_reg, scale_next;
    logic [DECAY_W-1:0] decay_reg, decay_next;
    logic [31:0]        last_count_reg, last_count_next;
    logic [31:0]        prev_diff_reg, prev_diff_next;
    logic [WIN_W-1:0]   window_len_reg, window_len_next;
    logic [DECAY_W-1:0] decay_power_reg, decay_power_next;
    logic [31:0]        last_vel_reg, last_vel_next;
    logic               started_reg, started_next;
    logic               restart_pending_reg, restart_pending_next;
    logic               upd_pend_reg, upd_pend_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        velocity_reg, velocity_next;
    logic               updated_reg, updated_next;

    // Datapath registers
    logic [64:0]        mul_reg;
    logic [31:0]        diff_reg;
    logic [47:0]        s2_reg;
    logic [46:0]        mag_reg;
    logic               neg_reg;
    logic [63:0]        lo_reg;
    logic [79:0]        num_reg;
    logic               sat_reg;
    logic [14:0]        div_rem_reg;
    logic [31:0]        quo_reg;
    logic [4:0]         div_cnt_reg;
    logic [31:0]        raw_reg;
    logic               fneg_reg;
    logic [32:0]        fmag_reg;

    // Combinational datapath
    logic [DECAY_W-1:0] dec;
    logic [WIN_W-1:0]   win_k;
    logic [14:0]        divisor;
    logic [14:0]        odd_factor;
    logic [32:0]        mul_a;
    logic [31:0]        mul_b;
    logic [64:0]        mul_p;
    logic [32:0]        pwr_sum;
    logic [DECAY_W-1:0] pwr_round;
    logic [DECAY_W-1:0] gain;
    logic               prev_neg;
    logic [31:0]        prev_mag;
    logic [47:0]        diff_ext;
    logic [47:0]        prod_ext;
    logic [47:0]        prod_signed;
    logic [47:0]        s2_val;
    logic [47:0]        s2_abs;
    logic [79:0]        num_val;
    logic               num_ovf;
    logic [15:0]        div_trial;
    logic               div_ge;
    logic [15:0]        div_sub;
    logic [31:0]        quo_neg;
    logic [31:0]        raw_val;
    logic [32:0]        fdiff;
    logic [32:0]        fdiff_abs;
    logic [49:0]        delta_sum;
    logic [32:0]        delta;
    logic [33:0]        vel_wide;
    logic               in_xact;
    logic               out_xact;
    logic               out_free;

    // Handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xact   = in_valid && !in_stall;
    assign out_xact  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign velocity  = velocity_reg;
    assign updated   = updated_reg;

    // Clamp decay to one; window length zero counts as one
    assign dec        = (decay_reg > ONE_Q16) ? ONE_Q16 : decay_reg;
    assign win_k      = (window_len_reg == '0) ? WIN_W'(1) : window_len_reg;
    assign divisor    = {win_k, 1'b0};
    assign odd_factor = divisor - 15'd3;
    assign gain       = ONE_Q16 - decay_power_reg;

    // Previous difference magnitude and sign
    assign prev_neg = prev_diff_reg[31];
    assign prev_mag = prev_neg ? (32'd0 - prev_diff_reg) : prev_diff_reg;

    // Select operands of the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_INIT:
            begin
                mul_a = {16'd0, dec};
                mul_b = {15'd0, dec};
            end
            ST_DECIDE:
            begin
                mul_a = {16'd0, decay_power_reg};
                mul_b = {15'd0, dec};
            end
            ST_PROD:
            begin
                mul_a = {1'b0, prev_mag};
                mul_b = {17'd0, odd_factor};
            end
            ST_MLO:
            begin
                mul_a = {1'b0, mag_reg[31:0]};
                mul_b = scale_reg;
            end
            ST_MHI:
            begin
                mul_a = {18'd0, mag_reg[46:32]};
                mul_b = scale_reg;
            end
            ST_FMUL:
            begin
                mul_a = fmag_reg;
                mul_b = {15'd0, gain};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {33'd0, mul_b};

    // Round a Q0.16 power product
    assign pwr_sum   = mul_reg[32:0] + HALF_Q16;
    assign pwr_round = pwr_sum[32:16];

    // Doubled trapezoidal sum
    assign diff_ext    = {{16{diff_reg[31]}}, diff_reg};
    assign prod_ext    = {1'b0, mul_reg[46:0]};
    assign prod_signed = prev_neg ? (48'd0 - prod_ext) : prod_ext;
    assign s2_val      = (win_k == WIN_W'(1)) ? {diff_ext[46:0], 1'b0}
                                              : (prod_signed + diff_ext);
    assign s2_abs      = s2_reg[47] ? (48'd0 - s2_reg) : s2_reg;

    // Numerator |s2|*scale + k, quotient overflow test
    assign num_val = {mul_reg[47:0], 32'd0} + {16'd0, lo_reg} + {66'd0, win_k};
    assign num_ovf = (num_reg[79:32] >= {33'd0, divisor});

    // One restoring divide step
    assign div_trial = {div_rem_reg, quo_reg[31]};
    assign div_ge    = (div_trial >= {1'b0, divisor});
    assign div_sub   = div_trial - {1'b0, divisor};

    // Signed, saturated raw velocity
    assign quo_neg = 32'd0 - quo_reg;
    always_comb
    begin
        if (neg_reg)
        begin
            raw_val = (sat_reg || (quo_reg > 32'h8000_0000)) ? 32'h8000_0000 : quo_neg;
        end
        else
        begin
            raw_val = (sat_reg || quo_reg[31]) ? 32'h7FFF_FFFF : quo_reg;
        end
    end

    // Filter step
    assign fdiff     = {raw_reg[31], raw_reg} - {last_vel_reg[31], last_vel_reg};
    assign fdiff_abs = fdiff[32] ? (33'd0 - fdiff) : fdiff;
    assign delta_sum = mul_reg[49:0] + {17'd0, HALF_Q16};
    assign delta     = delta_sum[48:16];
    assign vel_wide  = fneg_reg ? ({{2{last_vel_reg[31]}}, last_vel_reg} - {1'b0, delta})
                                : ({{2{last_vel_reg[31]}}, last_vel_reg} + {1'b0, delta});

    // Sequencer and architectural state next values
    always_comb
    begin
        state_next           = state_reg;
        scale_next           = scale_reg;
        decay_next           = decay_reg;
        last_count_next      = last_count_reg;
        prev_diff_next       = prev_diff_reg;
        window_len_next      = window_len_reg;
        decay_power_next     = decay_power_reg;
        last_vel_next        = last_vel_reg;
        started_next         = started_reg;
        restart_pending_next = restart_pending_reg;
        upd_pend_next        = upd_pend_reg;
        out_valid_next       = out_valid_reg;
        velocity_next        = velocity_reg;
        updated_next         = updated_reg;

        // Take configuration writes
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_VELOCITY_SCALE:   scale_next = cfg_data;
                REG_DECAY_PER_SAMPLE: decay_next = cfg_data[DECAY_W-1:0];
                default:              scale_next = scale_reg;
            endcase
        end

        // Drop a result once taken
        if (out_xact)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xact)
                begin
                    last_count_next = pulse_count;
                    state_next      = started_reg ? ST_DECIDE : ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = ST_INITP;
            end
            ST_INITP:
            begin
                decay_power_next = pwr_round;
                started_next     = 1'b1;
                state_next       = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                upd_pend_next = 1'b0;
                if (restart_pending_reg)
                begin
                    restart_pending_next = 1'b0;
                    prev_diff_next       = diff_reg;
                    window_len_next      = WIN_W'(1);
                    decay_power_next     = dec;
                    state_next           = ST_PUSH;
                end
                else if (diff_reg != prev_diff_reg)
                begin
                    state_next = ST_PROD;
                end
                else
                begin
                    if (window_len_reg > WIN_W'(HOLD_LIMIT))
                    begin
                        restart_pending_next = 1'b1;
                    end
                    window_len_next = window_len_reg + WIN_W'(1);
                    state_next      = ST_PWR;
                end
            end
            ST_PWR:
            begin
                decay_power_next = pwr_round;
                state_next       = ST_PUSH;
            end
            ST_PROD:  state_next = ST_S2;
            ST_S2:    state_next = ST_MAG;
            ST_MAG:   state_next = ST_MLO;
            ST_MLO:   state_next = ST_MHI;
            ST_MHI:   state_next = ST_NSUM;
            ST_NSUM:  state_next = ST_OVF;
            ST_OVF:
            begin
                state_next = num_ovf ? ST_RAW : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == 5'd31)
                begin
                    state_next = ST_RAW;
                end
            end
            ST_RAW:   state_next = ST_FDIFF;
            ST_FDIFF: state_next = ST_FMUL;
            ST_FMUL:  state_next = ST_FOUT;
            ST_FOUT:
            begin
                last_vel_next    = vel_wide[31:0];
                prev_diff_next   = diff_reg;
                window_len_next  = WIN_W'(1);
                decay_power_next = dec;
                upd_pend_next    = 1'b1;
                state_next       = ST_PUSH;
            end
            ST_PUSH:
            begin
                // Hold until the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    velocity_next  = last_vel_reg;
                    updated_next   = upd_pend_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, configuration and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            scale_reg           <= SCALE_RST;
            decay_reg           <= DECAY_RST;
            last_count_reg      <= '0;
            prev_diff_reg       <= '0;
            window_len_reg      <= WIN_W'(2);
            decay_power_reg     <= DECAY_POWER_RST;
            last_vel_reg        <= '0;
            started_reg         <= 1'b0;
            restart_pending_reg <= 1'b0;
            upd_pend_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            velocity_reg        <= '0;
            updated_reg         <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            scale_reg           <= scale_next;
            decay_reg           <= decay_next;
            last_count_reg      <= last_count_next;
            prev_diff_reg       <= prev_diff_next;
            window_len_reg      <= window_len_next;
            decay_power_reg     <= decay_power_next;
            last_vel_reg        <= last_vel_next;
            started_reg         <= started_next;
            restart_pending_reg <= restart_pending_next;
            upd_pend_reg        <= upd_pend_next;
            out_valid_reg       <= out_valid_next;
            velocity_reg        <= velocity_next;
            updated_reg         <= updated_next;
        end
    end

    // Advance the datapath registers
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_p;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xact)
                begin
                    diff_reg <= pulse_count - last_count_reg;
                end
            end
            ST_S2:
            begin
                s2_reg <= s2_val;
            end
            ST_MAG:
            begin
                mag_reg <= s2_abs[46:0];
                neg_reg <= s2_reg[47];
            end
            ST_MHI:
            begin
                lo_reg <= mul_reg[63:0];
            end
            ST_NSUM:
            begin
                num_reg <= num_val;
            end
            ST_OVF:
            begin
                sat_reg     <= num_ovf;
                div_rem_reg <= num_reg[46:32];
                quo_reg     <= num_reg[31:0];
                div_cnt_reg <= '0;
            end
            ST_DIV:
            begin
                div_rem_reg <= div_ge ? div_sub[14:0] : div_trial[14:0];
                quo_reg     <= {quo_reg[30:0], div_ge};
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            ST_RAW:
            begin
                raw_reg <= raw_val;
            end
            ST_FDIFF:
            begin
                fneg_reg <= fdiff[32];
                fmag_reg <= fdiff_abs;
            end
            default:
            begin
                mag_reg <= mag_reg;
            end
        endcase
    end

    // Assertions
    `ESMV_ASSERT_NXT(a_accept_busy, in_xact, state_reg != ST_IDLE, "sample accepted but sequencer idle")
    `ESMV_ASSERT_IMP(a_power_range, state_reg != ST_IDLE, decay_power_reg <= ONE_Q16, "decay power above one")
    `ESMV_ASSERT_IMP(a_restart_window, restart_pending_reg, window_len_reg > WIN_W'(HOLD_LIMIT), "restart pending with short window")
    `ESMV_ASSERT_IMP(a_div_rem, state_reg == ST_DIV, div_rem_reg < divisor, "divide remainder not below divisor")
    `ESMV_ASSERT_NXT(a_update_window, state_reg == ST_FOUT, (window_len_reg == WIN_W'(1)) && upd_pend_reg, "window not restarted after update")

endmodule

`default_nettype wire
